/* design/vrp_pkg.sv */
// Shared types, constants and helper functions for the vertex rotate and project unit.
package vrp_pkg;

    localparam int unsigned COORD_WIDTH = 32;
    localparam int unsigned TRIG_WIDTH  = 16;
    localparam int unsigned TRIG_FRAC   = 14;
    localparam int unsigned SCALE_WIDTH = 12;
    localparam int unsigned PIX_WIDTH   = 16;
    localparam int unsigned CFG_WIDTH   = COORD_WIDTH;
    localparam int unsigned CFG_IDX_W   = 3;
    // Product of a coordinate and a trig value, plus the sum of two such products
    localparam int unsigned PROD_WIDTH  = COORD_WIDTH + TRIG_WIDTH;
    localparam int unsigned SUM_WIDTH   = PROD_WIDTH + 1;
    // Scaled numerator and quotient widths for the pixel divide
    localparam int unsigned NUM_WIDTH   = COORD_WIDTH + SCALE_WIDTH;
    localparam int unsigned DIV_WIDTH   = NUM_WIDTH + 1;
    localparam int unsigned DEN_WIDTH   = COORD_WIDTH + 1;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = TRIG_WIDTH'(16384);
    localparam logic signed [PIX_WIDTH-1:0]  OFF_X    = PIX_WIDTH'(400);
    localparam logic signed [PIX_WIDTH-1:0]  OFF_Y    = PIX_WIDTH'(300);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_COS_X    = 3'd3,
        CFG_SIN_X    = 3'd4,
        CFG_COS_Y    = 3'd5,
        CFG_SIN_Y    = 3'd6,
        CFG_FOCAL    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic signed [COORD_WIDTH-1:0] vertex_z;
    } t_vertex_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
        logic signed [COORD_WIDTH-1:0] rotated_z;
        logic signed [PIX_WIDTH-1:0]   screen_x;
        logic signed [PIX_WIDTH-1:0]   screen_y;
        logic                          in_front;
    } t_vertex_out;

    // Rotated vertex handed from the front to the back
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rx;
        logic signed [COORD_WIDTH-1:0] ry;
        logic signed [COORD_WIDTH-1:0] rz;
        logic                          front;
    } t_rot_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic signed [TRIG_WIDTH-1:0]  cos_x;
        logic signed [TRIG_WIDTH-1:0]  sin_x;
        logic signed [TRIG_WIDTH-1:0]  cos_y;
        logic signed [TRIG_WIDTH-1:0]  sin_y;
        logic [SCALE_WIDTH-1:0]        focal;
    } t_cfg;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    function automatic logic signed [COORD_WIDTH-1:0] sat_add(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b,
        input logic                          sub
    );
        logic signed [COORD_WIDTH:0] s;
        s = sub ? ($signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b}))
                : ($signed({a[COORD_WIDTH-1], a}) + $signed({b[COORD_WIDTH-1], b}));
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
            return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        end
        return s[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [TRIG_WIDTH-1:0] clamp_trig(
        input logic signed [TRIG_WIDTH-1:0] t
    );
        if (t > TRIG_ONE) begin
            return TRIG_ONE;
        end
        if (t < -TRIG_ONE) begin
            return -TRIG_ONE;
        end
        return t;
    endfunction

    // Round a Q2.14 product sum to nearest, ties upward, and saturate
    function automatic logic signed [COORD_WIDTH-1:0] trig_round(
        input logic signed [SUM_WIDTH-1:0] p
    );
        logic signed [SUM_WIDTH:0] r;
        logic signed [SUM_WIDTH:0] q;
        r = $signed({p[SUM_WIDTH-1], p}) + $signed((SUM_WIDTH+1)'(1 << (TRIG_FRAC - 1)));
        q = r >>> TRIG_FRAC;
        if (q > $signed((SUM_WIDTH+1)'(COORD_MAX))) begin
            return COORD_MAX;
        end
        if (q < -$signed((SUM_WIDTH+1)'(COORD_MAX)) - 1) begin
            return COORD_MIN;
        end
        return q[COORD_WIDTH-1:0];
    endfunction

endpackage

/* design/vrp_front.sv */
// Rotation pipeline: centre subtract, X rotation, Y rotation, centre add.
module vrp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  vrp_pkg::t_vertex_in  i_vertex,
    input  vrp_pkg::t_cfg        i_cfg,
    output logic                 o_valid,
    output vrp_pkg::t_rot_item   o_item
);
    localparam int unsigned CW = vrp_pkg::COORD_WIDTH;
    localparam int unsigned PW = vrp_pkg::PROD_WIDTH;
    localparam int unsigned SW = vrp_pkg::SUM_WIDTH;

    logic signed [vrp_pkg::TRIG_WIDTH-1:0] cx, sx, cy, sy;
    assign cx = vrp_pkg::clamp_trig(i_cfg.cos_x);
    assign sx = vrp_pkg::clamp_trig(i_cfg.sin_x);
    assign cy = vrp_pkg::clamp_trig(i_cfg.cos_y);
    assign sy = vrp_pkg::clamp_trig(i_cfg.sin_y);

    logic [5:0] r_vld;

    // Stage 1: differences
    logic signed [CW-1:0] r_dx1, r_dy1, r_dz1;
    // Stage 2: X rotation products
    logic signed [PW-1:0] r_p_ycx, r_p_zsx, r_p_ysx, r_p_zcx;
    logic signed [CW-1:0] r_dx2;
    // Stage 3: rounded X rotation
    logic signed [CW-1:0] r_y1, r_z1, r_dx3;
    // Stage 4: Y rotation products
    logic signed [PW-1:0] r_p_xcy, r_p_zsy, r_p_xsy, r_p_zcy;
    logic signed [CW-1:0] r_y14;
    // Stage 5: rounded Y rotation
    logic signed [CW-1:0] r_x2, r_z2, r_y15;
    // Stage 6: centre added back
    logic signed [CW-1:0] r_rx, r_ry, r_rz;

    logic signed [CW-1:0] n_rz;
    assign n_rz = vrp_pkg::sat_add(r_z2, i_cfg.center_z, 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx1   <= vrp_pkg::sat_add(i_vertex.vertex_x, i_cfg.center_x, 1'b1);
        r_dy1   <= vrp_pkg::sat_add(i_vertex.vertex_y, i_cfg.center_y, 1'b1);
        r_dz1   <= vrp_pkg::sat_add(i_vertex.vertex_z, i_cfg.center_z, 1'b1);
        r_p_ycx <= PW'(r_dy1 * cx);
        r_p_zsx <= PW'(r_dz1 * sx);
        r_p_ysx <= PW'(r_dy1 * sx);
        r_p_zcx <= PW'(r_dz1 * cx);
        r_dx2   <= r_dx1;
        r_y1    <= vrp_pkg::trig_round(SW'(r_p_ycx) - SW'(r_p_zsx));
        r_z1    <= vrp_pkg::trig_round(SW'(r_p_ysx) + SW'(r_p_zcx));
        r_dx3   <= r_dx2;
        r_p_xcy <= PW'(r_dx3 * cy);
        r_p_zsy <= PW'(r_z1 * sy);
        r_p_xsy <= PW'(r_dx3 * sy);
        r_p_zcy <= PW'(r_z1 * cy);
        r_y14   <= r_y1;
        r_x2    <= vrp_pkg::trig_round(SW'(r_p_xcy) - SW'(r_p_zsy));
        r_z2    <= vrp_pkg::trig_round(SW'(r_p_xsy) + SW'(r_p_zcy));
        r_y15   <= r_y14;
        r_rx    <= vrp_pkg::sat_add(r_x2, i_cfg.center_x, 1'b0);
        r_ry    <= vrp_pkg::sat_add(r_y15, i_cfg.center_y, 1'b0);
        r_rz    <= n_rz;
    end

    assign o_valid     = r_vld[5];
    assign o_item.rx    = r_rx;
    assign o_item.ry    = r_ry;
    assign o_item.rz    = r_rz;
    assign o_item.front = (r_rz > 0);
endmodule

/* design/vrp_queue.sv */
// Short FIFO between the rotation front and the projection back.
module vrp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vrp_pkg::t_rot_item  i_item,
    input  logic                i_pop,
    output logic                o_valid,
    output vrp_pkg::t_rot_item  o_item
);
    localparam int unsigned AW = vrp_pkg::QUEUE_AW;

    vrp_pkg::t_rot_item r_mem [vrp_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop && o_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
endmodule

/* design/vrp_back.sv */
// Projection pipeline: scale, non-restoring-free pipelined divide, round and offset.
module vrp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  vrp_pkg::t_rot_item   i_item,
    input  logic [vrp_pkg::SCALE_WIDTH-1:0] i_focal,
    output logic                 o_pop,
    output logic                 o_valid,
    output vrp_pkg::t_vertex_out o_result
);
    localparam int unsigned CW = vrp_pkg::COORD_WIDTH;
    localparam int unsigned NW = vrp_pkg::NUM_WIDTH;
    localparam int unsigned DW = vrp_pkg::DIV_WIDTH;
    localparam int unsigned EW = vrp_pkg::DEN_WIDTH;
    localparam int unsigned PXW = vrp_pkg::PIX_WIDTH;
    localparam int unsigned ST = DW;

    typedef struct packed {
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic signed [CW-1:0] rz;
        logic                 front;
        logic                 neg_x;
        logic                 neg_y;
    } t_carry;

    // Never stalls: pop whenever something is waiting
    assign o_pop = i_valid;

    // Element 0 is the scale stage, elements 1..ST the divider stages
    logic          r_v  [ST+1];
    t_carry        r_c  [ST+1];
    logic [DW-1:0] r_nx [ST+1];
    logic [DW-1:0] r_ny [ST+1];
    logic [EW-1:0] r_d  [ST+1];
    logic [DW-1:0] r_qx [1:ST];
    logic [DW-1:0] r_qy [1:ST];
    logic [EW:0]   r_rx [1:ST];
    logic [EW:0]   r_ry [1:ST];

    // Stage 0: scaled magnitudes, numerators 2|n|+d, divisor 2d
    logic signed [NW-1:0] sx_n, sy_n;
    logic [NW-1:0]        ax, ay;
    assign sx_n = NW'(i_item.rx * $signed({1'b0, i_focal}));
    assign sy_n = NW'(i_item.ry * $signed({1'b0, i_focal}));
    assign ax   = sx_n[NW-1] ? NW'(-sx_n) : NW'(sx_n);
    assign ay   = sy_n[NW-1] ? NW'(-sy_n) : NW'(sy_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c[0].rx    <= i_item.rx;
        r_c[0].ry    <= i_item.ry;
        r_c[0].rz    <= i_item.rz;
        r_c[0].front <= i_item.front;
        r_c[0].neg_x <= sx_n[NW-1];
        r_c[0].neg_y <= sy_n[NW-1];
        r_nx[0] <= {ax, 1'b0} + DW'(i_item.rz[CW-1:0]);
        r_ny[0] <= {ay, 1'b0} + DW'(i_item.rz[CW-1:0]);
        r_d[0]  <= {i_item.rz[CW-2:0], 1'b0, 1'b0} >> 1;
    end

    // Restoring divide, one quotient bit per stage, both coordinates in parallel
    for (genvar g = 0; g < ST; g++) begin : g_div
        logic [EW:0]   rem_x, rem_y;
        logic [DW-1:0] quo_x, quo_y;
        logic [EW:0]   tx, ty;
        if (g == 0) begin : g_first
            assign rem_x = '0;
            assign rem_y = '0;
            assign quo_x = '0;
            assign quo_y = '0;
        end else begin : g_next
            assign rem_x = r_rx[g];
            assign rem_y = r_ry[g];
            assign quo_x = r_qx[g];
            assign quo_y = r_qy[g];
        end
        assign tx = {rem_x[EW-1:0], r_nx[g][DW-1]};
        assign ty = {rem_y[EW-1:0], r_ny[g][DW-1]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
        end
        always_ff @(posedge i_clk) begin
            r_c[g+1]  <= r_c[g];
            r_d[g+1]  <= r_d[g];
            r_nx[g+1] <= {r_nx[g][DW-2:0], 1'b0};
            r_ny[g+1] <= {r_ny[g][DW-2:0], 1'b0};
            if (tx >= {1'b0, r_d[g]}) begin
                r_rx[g+1] <= tx - {1'b0, r_d[g]};
                r_qx[g+1] <= {quo_x[DW-2:0], 1'b1};
            end else begin
                r_rx[g+1] <= tx;
                r_qx[g+1] <= {quo_x[DW-2:0], 1'b0};
            end
            if (ty >= {1'b0, r_d[g]}) begin
                r_ry[g+1] <= ty - {1'b0, r_d[g]};
                r_qy[g+1] <= {quo_y[DW-2:0], 1'b1};
            end else begin
                r_ry[g+1] <= ty;
                r_qy[g+1] <= {quo_y[DW-2:0], 1'b0};
            end
        end
    end

    function automatic logic signed [PXW-1:0] finish(
        input logic [DW-1:0]          q,
        input logic                   neg,
        input logic signed [PXW-1:0]  off
    );
        logic signed [DW+1:0] s;
        s = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        s = s + (DW+2)'(off);
        if (s > (DW+2)'(32767)) begin
            return PXW'(32767);
        end
        if (s < -(DW+2)'(32768)) begin
            return PXW'(-32768);
        end
        return s[PXW-1:0];
    endfunction

    logic                 r_vo;
    vrp_pkg::t_vertex_out r_res;
    t_carry               cl;
    assign cl = r_c[ST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_v[ST];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.rotated_x <= cl.rx;
        r_res.rotated_y <= cl.ry;
        r_res.rotated_z <= cl.rz;
        r_res.in_front  <= cl.front;
        r_res.screen_x  <= cl.front ? finish(r_qx[ST], cl.neg_x, vrp_pkg::OFF_X) : '0;
        r_res.screen_y  <= cl.front ? finish(r_qy[ST], cl.neg_y, vrp_pkg::OFF_Y) : '0;
    end

    assign o_valid  = r_vo;
    assign o_result = r_res;
endmodule

/* design/vertex_rotate_project_unit.sv */
// Vertex rotate and perspective project unit: top level with configuration registers.
// Takes one vertex per cycle whenever start is high; busy never rises. Each vertex
// produces one result, strobed on o_done for one cycle, through 54 register stages
// (6 rotation, 1 queue, 1 scale, 45 bit-per-stage pixel divider, 1 output), the first
// loading on the accepting edge.
// Results cannot be held off; write configuration only while no vertex is in flight.
module vertex_rotate_project_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  vrp_pkg::t_vertex_in                  i_vertex,
    input  logic                                 i_cfg_we,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [vrp_pkg::CFG_WIDTH-1:0]        i_cfg_data,
    output logic                                 o_done,
    output vrp_pkg::t_vertex_out                 o_result
);
    vrp_pkg::t_cfg r_cfg;
    vrp_pkg::t_cfg_idx widx;
    assign widx = vrp_pkg::t_cfg_idx'(i_cfg_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.center_z <= '0;
            r_cfg.cos_x    <= vrp_pkg::TRIG_WIDTH'(16362);
            r_cfg.sin_x    <= vrp_pkg::TRIG_WIDTH'(857);
            r_cfg.cos_y    <= vrp_pkg::TRIG_WIDTH'(16322);
            r_cfg.sin_y    <= vrp_pkg::TRIG_WIDTH'(1428);
            r_cfg.focal    <= vrp_pkg::SCALE_WIDTH'(400);
        end else if (i_cfg_we) begin
            case (widx)
                vrp_pkg::CFG_CENTER_X: r_cfg.center_x <= i_cfg_data;
                vrp_pkg::CFG_CENTER_Y: r_cfg.center_y <= i_cfg_data;
                vrp_pkg::CFG_CENTER_Z: r_cfg.center_z <= i_cfg_data;
                vrp_pkg::CFG_COS_X:    r_cfg.cos_x <= i_cfg_data[vrp_pkg::TRIG_WIDTH-1:0];
                vrp_pkg::CFG_SIN_X:    r_cfg.sin_x <= i_cfg_data[vrp_pkg::TRIG_WIDTH-1:0];
                vrp_pkg::CFG_COS_Y:    r_cfg.cos_y <= i_cfg_data[vrp_pkg::TRIG_WIDTH-1:0];
                vrp_pkg::CFG_SIN_Y:    r_cfg.sin_y <= i_cfg_data[vrp_pkg::TRIG_WIDTH-1:0];
                vrp_pkg::CFG_FOCAL:    r_cfg.focal <= i_cfg_data[vrp_pkg::SCALE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic               f_valid, q_valid, q_pop;
    vrp_pkg::t_rot_item f_item, q_item;

    vrp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_vertex (i_vertex),
        .i_cfg    (r_cfg),
        .o_valid  (f_valid),
        .o_item   (f_item)
    );

    vrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    vrp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .i_focal  (r_cfg.focal),
        .o_pop    (q_pop),
        .o_valid  (o_done),
        .o_result (o_result)
    );
endmodule
